>>> src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

>>> src/txm_pkg.sv
`default_nettype none

package txm_pkg;

  localparam int NAME_MAX   = 32;
  localparam int LINE_CHARS = 21;
  localparam int PAD_SPACES = 3;

  localparam int CHAR_W = 8;
  localparam int ADDR_W = $clog2(NAME_MAX);
  localparam int LEN_W  = 6;
  localparam int COL_W  = 5;

  localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'h20;

  localparam logic [LEN_W-1:0] LEN_MAX  = LEN_W'(NAME_MAX);
  localparam logic [LEN_W-1:0] LINE_LEN = LEN_W'(LINE_CHARS);
  localparam logic [LEN_W-1:0] PAD_LEN  = LEN_W'(PAD_SPACES);
  localparam logic [COL_W-1:0] COL_LAST = COL_W'(LINE_CHARS - 1);

  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_NEW  = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;

  typedef struct packed {
    logic [1:0]        op;
    logic [CHAR_W-1:0] ch;
  } cmd_t;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic [COL_W-1:0]  column;
    logic              last;
  } res_t;

endpackage

`default_nettype wire

>>> src/text_marquee_scroller_core.sv
// Scrolling text marquee. Both channels behave as queues. A request is
// accepted on in_push while in_full is low. A load request (in_func low)
// stores in_char_in as the next text character; in_first_char high starts a
// new text and rewinds the scroll position. Characters past 32 are dropped.
// A tick request (in_func high) produces 21 results, one per display column,
// each carrying out_char_out, out_column and out_last on the final column.
// Text of up to 21 characters is shown padded with spaces; longer text is
// shown as a ring with three trailing spaces and advances one place per tick.
// A result is presented while out_empty is low and taken with out_pop.
// A load request writes the name store when dequeued. A tick makes the
// sequencer issue one name-store read per column, one result per cycle while
// the output queue has room; each read is registered, then queued. Requests
// are not dequeued while the sequencer is busy with a tick's columns.
// Requests wait in a two-entry command queue; results wait in a four-entry
// output queue. When out_pop stays low, the output queue fills, the
// sequencer pauses and in_full rises once the command queue is full. Reset
// empties both queues and clears the text length and scroll position; the
// name store contents are not cleared.
`default_nettype none

module text_marquee_scroller_core (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           in_push,
  output logic                          in_full,
  input  wire                           in_func,
  input  wire  [txm_pkg::CHAR_W-1:0]    in_char_in,
  input  wire                           in_first_char,
  output logic                          out_empty,
  input  wire                           out_pop,
  output logic [txm_pkg::CHAR_W-1:0]    out_char_out,
  output logic [txm_pkg::COL_W-1:0]     out_column,
  output logic                          out_last
);

  logic          cmd_valid;
  logic          cmd_pop;
  txm_pkg::cmd_t cmd;

  txm_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_func       (in_func),
    .in_char_in    (in_char_in),
    .in_first_char (in_first_char),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .cmd_pop       (cmd_pop)
  );

  txm_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_pop      (cmd_pop),
    .out_empty    (out_empty),
    .out_pop      (out_pop),
    .out_char_out (out_char_out),
    .out_column   (out_column),
    .out_last     (out_last)
  );

endmodule

`default_nettype wire

>>> src/txm_front.sv
`default_nettype none

`include "assert_macros.svh"

module txm_front (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           in_push,
  output logic                          in_full,
  input  wire                           in_func,
  input  wire  [txm_pkg::CHAR_W-1:0]    in_char_in,
  input  wire                           in_first_char,
  output logic                          cmd_valid,
  output txm_pkg::cmd_t                 cmd,
  input  wire                           cmd_pop
);

  txm_pkg::cmd_t q_r [2];
  logic          wp_r, wp_nxt;
  logic          rp_r, rp_nxt;
  logic [1:0]    cnt_r, cnt_nxt;
  logic          push_acc;
  txm_pkg::cmd_t cmd_in;

  always_comb begin
    cmd_in.ch = in_char_in;
    if (in_func) begin
      cmd_in.op = txm_pkg::OP_TICK;
    end else if (in_first_char) begin
      cmd_in.op = txm_pkg::OP_NEW;
    end else begin
      cmd_in.op = txm_pkg::OP_LOAD;
    end
  end

  assign in_full   = (cnt_r == 2'd2);
  assign push_acc  = in_push && !in_full;
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r ^ push_acc;
    rp_nxt  = rp_r ^ cmd_pop;
    cnt_nxt = cnt_r + 2'(push_acc) - 2'(cmd_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_acc) begin
      q_r[wp_r] <= cmd_in;
    end
  end

  `ASSERT_ALWAYS(a_cnt_bound, clk, rst_n, cnt_r <= 2'd2)
  `ASSERT_IMPLIES(a_pop_nonempty, clk, rst_n, cmd_pop, cmd_valid)
  `ASSERT_NEXT(a_push_grows, clk, rst_n, push_acc && !cmd_pop, cnt_r == $past(cnt_r) + 2'd1)

endmodule

`default_nettype wire

>>> src/txm_back.sv
`default_nettype none

`include "assert_macros.svh"

module txm_back (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           cmd_valid,
  input  txm_pkg::cmd_t                 cmd,
  output logic                          cmd_pop,
  output logic                          out_empty,
  input  wire                           out_pop,
  output logic [txm_pkg::CHAR_W-1:0]    out_char_out,
  output logic [txm_pkg::COL_W-1:0]     out_column,
  output logic                          out_last
);

  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW    = $clog2(OQ_DEPTH);
  localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

  logic [txm_pkg::CHAR_W-1:0] mem [txm_pkg::NAME_MAX];
  logic [txm_pkg::CHAR_W-1:0] mem_q_r;

  logic [txm_pkg::LEN_W-1:0]  len_r, len_nxt;
  logic [txm_pkg::LEN_W-1:0]  off_r, off_nxt;
  logic [txm_pkg::LEN_W-1:0]  base_r, base_nxt;
  logic                       long_r, long_nxt;
  logic                       busy_r, busy_nxt;
  logic [txm_pkg::COL_W-1:0]  col_r, col_nxt;

  logic                       rd_v_r;
  logic                       rd_space_r;
  logic [txm_pkg::COL_W-1:0]  rd_col_r;

  txm_pkg::res_t              oq_r [OQ_DEPTH];
  logic [OQ_AW-1:0]           owp_r, orp_r;
  logic [OQ_CW-1:0]           ocnt_r;

  logic [txm_pkg::LEN_W-1:0]  ring;
  logic [txm_pkg::LEN_W-1:0]  pos;
  logic [txm_pkg::LEN_W-1:0]  pos_w;
  logic [txm_pkg::LEN_W-1:0]  off_inc;
  logic                       issue;
  logic                       issue_last;
  logic                       we;
  logic [txm_pkg::ADDR_W-1:0] wa;
  logic                       pop_acc;
  txm_pkg::res_t              oq_in;

  assign ring       = len_r + txm_pkg::PAD_LEN;
  assign pos        = base_r + txm_pkg::LEN_W'(col_r);
  assign pos_w      = (long_r && (pos >= ring)) ? (pos - ring) : pos;
  assign off_inc    = off_r + 6'd1;
  assign issue      = busy_r && ((ocnt_r + OQ_CW'(rd_v_r)) < OQ_CW'(OQ_DEPTH));
  assign issue_last = issue && (col_r == txm_pkg::COL_LAST);
  assign cmd_pop    = cmd_valid && !busy_r;
  assign pop_acc    = out_pop && !out_empty;

  always_comb begin
    len_nxt  = len_r;
    off_nxt  = off_r;
    base_nxt = base_r;
    long_nxt = long_r;
    busy_nxt = busy_r;
    col_nxt  = col_r;
    we       = 1'b0;
    wa       = len_r[txm_pkg::ADDR_W-1:0];
    if (cmd_pop) begin
      case (cmd.op)
        txm_pkg::OP_NEW: begin
          we      = 1'b1;
          wa      = '0;
          len_nxt = 6'd1;
          off_nxt = '0;
        end
        txm_pkg::OP_LOAD: begin
          if (len_r < txm_pkg::LEN_MAX) begin
            we      = 1'b1;
            len_nxt = len_r + 6'd1;
          end
        end
        txm_pkg::OP_TICK: begin
          busy_nxt = 1'b1;
          col_nxt  = '0;
          long_nxt = (len_r > txm_pkg::LINE_LEN);
          base_nxt = (len_r > txm_pkg::LINE_LEN) ? off_r : '0;
        end
        default: begin
        end
      endcase
    end
    if (issue) begin
      col_nxt = col_r + 5'd1;
      if (issue_last) begin
        busy_nxt = 1'b0;
        if (long_r) begin
          off_nxt = (off_inc >= ring) ? '0 : off_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r  <= '0;
      off_r  <= '0;
      busy_r <= 1'b0;
      rd_v_r <= 1'b0;
      owp_r  <= '0;
      orp_r  <= '0;
      ocnt_r <= '0;
    end else begin
      len_r  <= len_nxt;
      off_r  <= off_nxt;
      busy_r <= busy_nxt;
      rd_v_r <= issue;
      owp_r  <= owp_r + OQ_AW'(rd_v_r);
      orp_r  <= orp_r + OQ_AW'(pop_acc);
      ocnt_r <= ocnt_r + OQ_CW'(rd_v_r) - OQ_CW'(pop_acc);
    end
  end

  always_ff @(posedge clk) begin
    base_r <= base_nxt;
    long_r <= long_nxt;
    col_r  <= col_nxt;
    if (issue) begin
      rd_space_r <= (pos_w >= len_r);
      rd_col_r   <= col_r;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= cmd.ch;
    end
    if (issue) begin
      mem_q_r <= mem[pos_w[txm_pkg::ADDR_W-1:0]];
    end
  end

  always_comb begin
    oq_in.ch     = rd_space_r ? txm_pkg::SPACE_CHAR : mem_q_r;
    oq_in.column = rd_col_r;
    oq_in.last   = (rd_col_r == txm_pkg::COL_LAST);
  end

  always_ff @(posedge clk) begin
    if (rd_v_r) begin
      oq_r[owp_r] <= oq_in;
    end
  end

  assign out_empty    = (ocnt_r == '0);
  assign out_char_out = oq_r[orp_r].ch;
  assign out_column   = oq_r[orp_r].column;
  assign out_last     = oq_r[orp_r].last;

  `ASSERT_ALWAYS(a_oq_bound, clk, rst_n, ocnt_r <= OQ_CW'(OQ_DEPTH))
  `ASSERT_IMPLIES(a_col_range, clk, rst_n, busy_r, col_r <= txm_pkg::COL_LAST)
  `ASSERT_IMPLIES(a_off_in_ring, clk, rst_n, len_r > txm_pkg::LINE_LEN, off_r < ring)

endmodule

`default_nettype wire
